@@ rtl/core/ensc_pkg.sv @@
// Shared types, codes and the microcode program for the sensor compensation block.
package ensc_pkg;

  typedef struct packed {
    logic [23:0] raw_temp;
    logic [23:0] raw_press;
    logic [15:0] raw_hum;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic signed [31:0] press_q8;
    logic [16:0]        hum_q10;
    logic               temp_skipped;
    logic               press_skipped;
    logic               hum_skipped;
    logic               press_div_zero;
  } out_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM   = 3'd5;

  localparam logic [23:0] RAW24_OFF = 24'h800000;
  localparam logic [15:0] RAW16_OFF = 16'h8000;
  localparam logic signed [31:0] HUM_MAX = 32'sd419430400;
  localparam int DIV_STEPS = 64;

  // micro-op codes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_SHL  = 4'd3;
  localparam logic [3:0] OP_SDIV = 4'd4;   // signed divide by 2^k, toward zero
  localparam logic [3:0] OP_DIV  = 4'd5;   // signed 64-bit divide, iterative
  localparam logic [3:0] OP_FINE = 4'd6;
  localparam logic [3:0] OP_OUTT = 4'd7;
  localparam logic [3:0] OP_OUTP = 4'd8;
  localparam logic [3:0] OP_OUTH = 4'd9;
  localparam logic [3:0] OP_BR   = 4'd10;
  localparam logic [3:0] OP_DZ   = 4'd11;
  localparam logic [3:0] OP_END  = 4'd12;

  // operand codes: 0..7 are working registers
  localparam logic [4:0] R0 = 5'd0, R1 = 5'd1, R2 = 5'd2, R3 = 5'd3, R4 = 5'd4;
  localparam logic [4:0] O_T1 = 5'd8,  O_T2 = 5'd9,  O_T3 = 5'd10;
  localparam logic [4:0] O_P1 = 5'd11, O_P2 = 5'd12, O_P3 = 5'd13, O_P4 = 5'd14;
  localparam logic [4:0] O_P5 = 5'd15, O_P6 = 5'd16, O_P7 = 5'd17, O_P8 = 5'd18;
  localparam logic [4:0] O_P9 = 5'd19;
  localparam logic [4:0] O_H1 = 5'd20, O_H2 = 5'd21, O_H3 = 5'd22, O_H4 = 5'd23;
  localparam logic [4:0] O_H5 = 5'd24, O_H6 = 5'd25;
  localparam logic [4:0] O_TRIM = 5'd26, O_FINE = 5'd27, O_ADCT = 5'd28;
  localparam logic [4:0] O_ADCP = 5'd29, O_RH = 5'd30, O_IMM = 5'd31;

  // branch conditions, carried in the destination field
  localparam logic [4:0] C_ALWAYS = 5'd0;
  localparam logic [4:0] C_TSKIP  = 5'd1;
  localparam logic [4:0] C_PSKIP  = 5'd2;
  localparam logic [4:0] C_HSKIP  = 5'd3;
  localparam logic [4:0] C_ZERO   = 5'd4;

  // immediate table indexes, carried in k
  localparam logic [6:0] I_5 = 7'd0, I_128 = 7'd1, I_128000 = 7'd2, I_76800 = 7'd3;
  localparam logic [6:0] I_3125 = 7'd4, I_2P20 = 7'd5, I_2P47 = 7'd6, I_16384 = 7'd7;
  localparam logic [6:0] I_32768 = 7'd8, I_2P21 = 7'd9, I_8192 = 7'd10;

  localparam int PC_W = 7;
  localparam logic [PC_W-1:0] PROG_LEN = 7'd85;
  localparam logic [6:0] L_PRESS = 7'd19;
  localparam logic [6:0] L_DZ    = 7'd55;
  localparam logic [6:0] L_HUM   = 7'd56;
  localparam logic [6:0] L_END   = 7'd84;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] dst;
    logic [4:0] a;
    logic [4:0] b;
    logic [6:0] k;
    logic       w;     // wrap the result to int32
  } instr_t;

  typedef struct packed {
    instr_t     ins;
    logic       load;
    logic       wr;
    logic [1:0] mul_phase;
    logic       div_start;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic tskip;
    logic pskip;
    logic hskip;
    logic a_zero;
    logic div_done;
  } stat_t;

  function automatic logic [63:0] imm_val(input logic [6:0] k);
    logic [63:0] v;
    case (k)
      I_5:      v = 64'd5;
      I_128:    v = 64'd128;
      I_128000: v = 64'd128000;
      I_76800:  v = 64'd76800;
      I_3125:   v = 64'd3125;
      I_2P20:   v = 64'd1048576;
      I_2P47:   v = 64'd140737488355328;
      I_16384:  v = 64'd16384;
      I_32768:  v = 64'd32768;
      I_2P21:   v = 64'd2097152;
      I_8192:   v = 64'd8192;
      default:  v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic instr_t mk(input logic [3:0] op, input logic [4:0] d,
                                input logic [4:0] a, input logic [4:0] b,
                                input logic [6:0] k, input logic w);
    instr_t i;
    i.op  = op;
    i.dst = d[2:0];
    i.a   = a;
    i.b   = b;
    i.k   = k;
    i.w   = w;
    return i;
  endfunction

  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t p;
    case (pc)
      // temperature
      7'd0:  p = mk(OP_BR,   C_TSKIP, R0, R0, L_PRESS, 1'b0);
      7'd1:  p = mk(OP_SDIV, R0, O_ADCT, R0, 7'd3, 1'b1);
      7'd2:  p = mk(OP_SHL,  R1, O_T1, R0, 7'd1, 1'b1);
      7'd3:  p = mk(OP_SUB,  R0, R0, R1, 7'd0, 1'b1);
      7'd4:  p = mk(OP_MUL,  R0, R0, O_T2, 7'd0, 1'b1);
      7'd5:  p = mk(OP_SDIV, R0, R0, R0, 7'd11, 1'b1);
      7'd6:  p = mk(OP_SDIV, R1, O_ADCT, R0, 7'd4, 1'b1);
      7'd7:  p = mk(OP_SUB,  R1, R1, O_T1, 7'd0, 1'b1);
      7'd8:  p = mk(OP_MUL,  R1, R1, R1, 7'd0, 1'b1);
      7'd9:  p = mk(OP_SDIV, R1, R1, R0, 7'd12, 1'b1);
      7'd10: p = mk(OP_MUL,  R1, R1, O_T3, 7'd0, 1'b1);
      7'd11: p = mk(OP_SDIV, R1, R1, R0, 7'd14, 1'b1);
      7'd12: p = mk(OP_ADD,  R0, R0, R1, 7'd0, 1'b1);
      7'd13: p = mk(OP_ADD,  R0, R0, O_TRIM, 7'd0, 1'b1);
      7'd14: p = mk(OP_FINE, R0, R0, R0, 7'd0, 1'b0);
      7'd15: p = mk(OP_MUL,  R1, R0, O_IMM, I_5, 1'b1);
      7'd16: p = mk(OP_ADD,  R1, R1, O_IMM, I_128, 1'b1);
      7'd17: p = mk(OP_SDIV, R1, R1, R0, 7'd8, 1'b1);
      7'd18: p = mk(OP_OUTT, R0, R1, R0, 7'd0, 1'b0);
      // pressure
      7'd19: p = mk(OP_BR,   C_PSKIP, R0, R0, L_HUM, 1'b0);
      7'd20: p = mk(OP_SUB,  R0, O_FINE, O_IMM, I_128000, 1'b0);
      7'd21: p = mk(OP_MUL,  R1, R0, R0, 7'd0, 1'b0);
      7'd22: p = mk(OP_MUL,  R2, R1, O_P6, 7'd0, 1'b0);
      7'd23: p = mk(OP_MUL,  R3, R0, O_P5, 7'd0, 1'b0);
      7'd24: p = mk(OP_SHL,  R3, R3, R0, 7'd17, 1'b0);
      7'd25: p = mk(OP_ADD,  R2, R2, R3, 7'd0, 1'b0);
      7'd26: p = mk(OP_SHL,  R3, O_P4, R0, 7'd35, 1'b0);
      7'd27: p = mk(OP_ADD,  R2, R2, R3, 7'd0, 1'b0);
      7'd28: p = mk(OP_MUL,  R1, R1, O_P3, 7'd0, 1'b0);
      7'd29: p = mk(OP_SDIV, R1, R1, R0, 7'd8, 1'b0);
      7'd30: p = mk(OP_MUL,  R3, R0, O_P2, 7'd0, 1'b0);
      7'd31: p = mk(OP_SHL,  R3, R3, R0, 7'd12, 1'b0);
      7'd32: p = mk(OP_ADD,  R1, R1, R3, 7'd0, 1'b0);
      7'd33: p = mk(OP_ADD,  R1, R1, O_IMM, I_2P47, 1'b0);
      7'd34: p = mk(OP_MUL,  R1, R1, O_P1, 7'd0, 1'b0);
      7'd35: p = mk(OP_SDIV, R1, R1, R0, 7'd33, 1'b0);
      7'd36: p = mk(OP_BR,   C_ZERO, R1, R0, L_DZ, 1'b0);
      7'd37: p = mk(OP_SUB,  R0, O_IMM, O_ADCP, I_2P20, 1'b0);
      7'd38: p = mk(OP_SHL,  R0, R0, R0, 7'd31, 1'b0);
      7'd39: p = mk(OP_SUB,  R0, R0, R2, 7'd0, 1'b0);
      7'd40: p = mk(OP_MUL,  R0, R0, O_IMM, I_3125, 1'b0);
      7'd41: p = mk(OP_DIV,  R0, R0, R1, 7'd0, 1'b0);
      7'd42: p = mk(OP_SDIV, R2, R0, R0, 7'd13, 1'b0);
      7'd43: p = mk(OP_MUL,  R3, R2, O_P9, 7'd0, 1'b0);
      7'd44: p = mk(OP_MUL,  R3, R3, R2, 7'd0, 1'b0);
      7'd45: p = mk(OP_SDIV, R3, R3, R0, 7'd25, 1'b0);
      7'd46: p = mk(OP_MUL,  R4, R0, O_P8, 7'd0, 1'b0);
      7'd47: p = mk(OP_SDIV, R4, R4, R0, 7'd19, 1'b0);
      7'd48: p = mk(OP_ADD,  R0, R0, R3, 7'd0, 1'b0);
      7'd49: p = mk(OP_ADD,  R0, R0, R4, 7'd0, 1'b0);
      7'd50: p = mk(OP_SDIV, R0, R0, R0, 7'd8, 1'b0);
      7'd51: p = mk(OP_SHL,  R4, O_P7, R0, 7'd4, 1'b0);
      7'd52: p = mk(OP_ADD,  R0, R0, R4, 7'd0, 1'b0);
      7'd53: p = mk(OP_OUTP, R0, R0, R0, 7'd0, 1'b0);
      7'd54: p = mk(OP_BR,   C_ALWAYS, R0, R0, L_HUM, 1'b0);
      7'd55: p = mk(OP_DZ,   R0, R0, R0, 7'd0, 1'b0);
      // humidity
      7'd56: p = mk(OP_BR,   C_HSKIP, R0, R0, L_END, 1'b0);
      7'd57: p = mk(OP_SUB,  R0, O_FINE, O_IMM, I_76800, 1'b1);
      7'd58: p = mk(OP_SHL,  R1, O_RH, R0, 7'd14, 1'b1);
      7'd59: p = mk(OP_SHL,  R2, O_H4, R0, 7'd20, 1'b1);
      7'd60: p = mk(OP_SUB,  R1, R1, R2, 7'd0, 1'b1);
      7'd61: p = mk(OP_MUL,  R2, O_H5, R0, 7'd0, 1'b1);
      7'd62: p = mk(OP_SUB,  R1, R1, R2, 7'd0, 1'b1);
      7'd63: p = mk(OP_ADD,  R1, R1, O_IMM, I_16384, 1'b1);
      7'd64: p = mk(OP_SDIV, R1, R1, R0, 7'd15, 1'b1);
      7'd65: p = mk(OP_MUL,  R2, R0, O_H6, 7'd0, 1'b1);
      7'd66: p = mk(OP_SDIV, R2, R2, R0, 7'd10, 1'b1);
      7'd67: p = mk(OP_MUL,  R3, R0, O_H3, 7'd0, 1'b1);
      7'd68: p = mk(OP_SDIV, R3, R3, R0, 7'd11, 1'b1);
      7'd69: p = mk(OP_ADD,  R3, R3, O_IMM, I_32768, 1'b1);
      7'd70: p = mk(OP_MUL,  R2, R2, R3, 7'd0, 1'b1);
      7'd71: p = mk(OP_SDIV, R2, R2, R0, 7'd10, 1'b1);
      7'd72: p = mk(OP_ADD,  R2, R2, O_IMM, I_2P21, 1'b1);
      7'd73: p = mk(OP_MUL,  R2, R2, O_H2, 7'd0, 1'b1);
      7'd74: p = mk(OP_ADD,  R2, R2, O_IMM, I_8192, 1'b1);
      7'd75: p = mk(OP_SDIV, R2, R2, R0, 7'd14, 1'b1);
      7'd76: p = mk(OP_MUL,  R1, R1, R2, 7'd0, 1'b1);
      7'd77: p = mk(OP_SDIV, R2, R1, R0, 7'd15, 1'b1);
      7'd78: p = mk(OP_MUL,  R2, R2, R2, 7'd0, 1'b1);
      7'd79: p = mk(OP_SDIV, R2, R2, R0, 7'd7, 1'b1);
      7'd80: p = mk(OP_MUL,  R2, R2, O_H1, 7'd0, 1'b1);
      7'd81: p = mk(OP_SDIV, R2, R2, R0, 7'd4, 1'b1);
      7'd82: p = mk(OP_SUB,  R1, R1, R2, 7'd0, 1'b1);
      7'd83: p = mk(OP_OUTH, R0, R1, R0, 7'd0, 1'b0);
      default: p = mk(OP_END, R0, R0, R0, 7'd0, 1'b0);
    endcase
    return p;
  endfunction

endpackage

@@ rtl/core/ensc_div.sv @@
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
module ensc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  import ensc_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [63:0]      rem;
  logic [63:0]      dq;
  logic [63:0]      ud;
  logic             neg;
  logic             dz;
  logic [64:0]      trial;
  logic [64:0]      diff;

  assign trial = {rem, dq[63]};
  assign diff  = trial - {1'b0, ud};

  // restoring shift-subtract on magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= num[63] ? (64'd0 - num) : num;
      ud  <= den[63] ? (64'd0 - den) : den;
      rem <= '0;
      neg <= num[63] ^ den[63];
      dz  <= (den == 64'd0);
    end else if (busy) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
        dq  <= {dq[62:0], 1'b1};
      end else begin
        rem <= trial[63:0];
        dq  <= {dq[62:0], 1'b0};
      end
    end
  end

  assign quo = dz ? 64'd0 : (neg ? (64'd0 - dq) : dq);

endmodule

@@ rtl/core/ensc_datapath.sv @@
// Datapath: coefficient registers, working register file, shared multiplier, divider.
module ensc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ensc_pkg::cmd_t                    cmd,
  output ensc_pkg::stat_t                   stat,
  input  ensc_pkg::in_t                     in_data,
  input  logic                              cfg_we,
  input  logic [ensc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ensc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ensc_pkg::out_t                    out_data
);
  import ensc_pkg::*;

  logic [47:0] temp_coeffs;
  logic [63:0] press_lo;
  logic [63:0] press_hi;
  logic [15:0] press_last;
  logic [63:0] hum_coeffs;
  logic [31:0] temp_trim;
  logic [31:0] fine;

  in_t  raw;
  out_t res;
  out_t res_init;
  out_t out_q;

  logic [63:0] rf [0:7];
  logic [63:0] rd_a;
  logic [63:0] rd_b;
  logic [63:0] va;
  logic [63:0] vb;
  logic [63:0] acc;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] prod;
  logic [63:0] mul_res;
  logic [63:0] bias;
  logic [63:0] sdiv_res;
  logic [63:0] alu;
  logic [63:0] wdata;
  logic [63:0] quo;
  logic        div_done;
  logic        rf_we;
  logic signed [31:0] hs;
  logic [31:0] hcl;
  logic [31:0] psat;

  function automatic logic [63:0] sel(input logic [4:0] c, input logic [63:0] rd,
                                      input logic [6:0] k);
    logic [63:0] v;
    case (c)
      O_T1:   v = {48'd0, temp_coeffs[15:0]};
      O_T2:   v = 64'($signed(temp_coeffs[31:16]));
      O_T3:   v = 64'($signed(temp_coeffs[47:32]));
      O_P1:   v = {48'd0, press_lo[15:0]};
      O_P2:   v = 64'($signed(press_lo[31:16]));
      O_P3:   v = 64'($signed(press_lo[47:32]));
      O_P4:   v = 64'($signed(press_lo[63:48]));
      O_P5:   v = 64'($signed(press_hi[15:0]));
      O_P6:   v = 64'($signed(press_hi[31:16]));
      O_P7:   v = 64'($signed(press_hi[47:32]));
      O_P8:   v = 64'($signed(press_hi[63:48]));
      O_P9:   v = 64'($signed(press_last));
      O_H1:   v = {56'd0, hum_coeffs[7:0]};
      O_H2:   v = 64'($signed(hum_coeffs[23:8]));
      O_H3:   v = {56'd0, hum_coeffs[31:24]};
      O_H4:   v = 64'($signed(hum_coeffs[43:32]));
      O_H5:   v = 64'($signed(hum_coeffs[55:44]));
      O_H6:   v = 64'($signed(hum_coeffs[63:56]));
      O_TRIM: v = 64'($signed(temp_trim));
      O_FINE: v = 64'($signed(fine));
      O_ADCT: v = {44'd0, raw.raw_temp[23:4]};
      O_ADCP: v = {44'd0, raw.raw_press[23:4]};
      O_RH:   v = {48'd0, raw.raw_hum};
      O_IMM:  v = imm_val(k);
      default: v = rd;
    endcase
    return v;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_lo    <= '0;
      press_hi    <= '0;
      press_last  <= '0;
      hum_coeffs  <= '0;
      temp_trim   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP:  temp_coeffs <= cfg_data[47:0];
        CFG_PLOW:  press_lo    <= cfg_data;
        CFG_PHIGH: press_hi    <= cfg_data;
        CFG_PLAST: press_last  <= cfg_data[15:0];
        CFG_HUM:   hum_coeffs  <= cfg_data;
        CFG_TRIM:  temp_trim   <= cfg_data[31:0];
        default:   ;
      endcase
    end
  end

  // register file, registered reads
  always_ff @(posedge clk) begin
    if (rf_we) rf[cmd.ins.dst] <= wdata;
    rd_a <= rf[cmd.ins.a[2:0]];
    rd_b <= rf[cmd.ins.b[2:0]];
  end

  assign va = sel(cmd.ins.a, rd_a, cmd.ins.k);
  assign vb = sel(cmd.ins.b, rd_b, cmd.ins.k);

  // 64x64 low product from three 32x32 partial products
  assign mx      = (cmd.mul_phase == 2'd2) ? va[63:32] : va[31:0];
  assign my      = (cmd.mul_phase == 2'd1) ? vb[63:32] : vb[31:0];
  assign prod    = {32'd0, mx} * {32'd0, my};
  assign mul_res = acc + {prod[31:0], 32'd0};

  always_ff @(posedge clk) begin
    case (cmd.mul_phase)
      2'd0:    acc <= prod;
      2'd1:    acc <= mul_res;
      default: acc <= acc;
    endcase
  end

  // signed divide by a power of two, rounding toward zero
  assign bias     = va[63] ? ((64'd1 << cmd.ins.k[5:0]) - 64'd1) : 64'd0;
  assign sdiv_res = 64'($signed(va + bias) >>> cmd.ins.k[5:0]);

  ensc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (va),
    .den   (vb),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    case (cmd.ins.op)
      OP_ADD:  alu = va + vb;
      OP_SUB:  alu = va - vb;
      OP_MUL:  alu = mul_res;
      OP_SHL:  alu = va << cmd.ins.k[5:0];
      OP_SDIV: alu = sdiv_res;
      OP_DIV:  alu = quo;
      default: alu = va;
    endcase
    wdata = cmd.ins.w ? 64'($signed(alu[31:0])) : alu;
    rf_we = cmd.wr && (cmd.ins.op == OP_ADD || cmd.ins.op == OP_SUB ||
                       cmd.ins.op == OP_MUL || cmd.ins.op == OP_SHL ||
                       cmd.ins.op == OP_SDIV || cmd.ins.op == OP_DIV);
  end

  // pressure saturation and humidity clamp
  always_comb begin
    if ($signed(va) > 64'sh7FFFFFFF)          psat = 32'h7FFFFFFF;
    else if ($signed(va) < -64'sh80000000)    psat = 32'h80000000;
    else                                      psat = va[31:0];
    hs = $signed(va[31:0]);
    if (hs < 0)             hcl = 32'd0;
    else if (hs > HUM_MAX)  hcl = HUM_MAX;
    else                    hcl = hs;
  end

  // fine temperature state
  always_ff @(posedge clk) begin
    if (rst) begin
      fine <= '0;
    end else if (cmd.wr && cmd.ins.op == OP_FINE) begin
      fine <= va[31:0];
    end
  end

  // cleared result with the skip flags of the incoming beat
  always_comb begin
    res_init               = '0;
    res_init.temp_skipped  = (in_data.raw_temp == RAW24_OFF);
    res_init.press_skipped = (in_data.raw_press == RAW24_OFF);
    res_init.hum_skipped   = (in_data.raw_hum == RAW16_OFF);
  end

  // input capture, working result, output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw <= in_data;
      res <= res_init;
    end else if (cmd.wr) begin
      case (cmd.ins.op)
        OP_OUTT: res.temp_centi     <= va[31:0];
        OP_OUTP: res.press_q8       <= psat;
        OP_OUTH: res.hum_q10        <= hcl[28:12];
        OP_DZ:   res.press_div_zero <= 1'b1;
        default: ;
      endcase
    end
    if (cmd.publish) out_q <= res;
  end

  assign out_data      = out_q;
  assign stat.tskip    = res.temp_skipped;
  assign stat.pskip    = res.press_skipped;
  assign stat.hskip    = res.hum_skipped;
  assign stat.a_zero   = (va == 64'd0);
  assign stat.div_done = div_done;

endmodule

@@ rtl/core/ensc_ctrl.sv @@
// Controller: microcode sequencer over the compensation program, and handshakes.
module ensc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ensc_pkg::stat_t stat,
  output ensc_pkg::cmd_t  cmd
);
  import ensc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [1:0]      mph;
  logic [1:0]      mph_next;
  logic            taken;
  instr_t          ins;

  assign ins = prog(pc);

  always_comb begin
    case (5'(ins.dst))
      C_ALWAYS: taken = 1'b1;
      C_TSKIP:  taken = stat.tskip;
      C_PSKIP:  taken = stat.pskip;
      C_HSKIP:  taken = stat.hskip;
      C_ZERO:   taken = stat.a_zero;
      default:  taken = 1'b0;
    endcase
  end

  // sequencing
  always_comb begin
    state_next    = state;
    pc_next       = pc;
    mph_next      = mph;
    in_ready      = 1'b0;
    cmd.ins       = ins;
    cmd.load      = 1'b0;
    cmd.wr        = 1'b0;
    cmd.mul_phase = 2'd0;
    cmd.div_start = 1'b0;
    cmd.publish   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          pc_next    = '0;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        case (ins.op)
          OP_MUL: begin
            mph_next   = 2'd1;
            state_next = S_MUL;
          end
          OP_DIV: begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
          OP_BR: begin
            pc_next    = taken ? ins.k : pc + 1'b1;
            state_next = S_FETCH;
          end
          OP_END: begin
            state_next = S_DONE;
          end
          default: begin
            cmd.wr     = 1'b1;
            pc_next    = pc + 1'b1;
            state_next = S_FETCH;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul_phase = mph;
        if (mph == 2'd2) begin
          cmd.wr     = 1'b1;
          pc_next    = pc + 1'b1;
          state_next = S_FETCH;
        end else begin
          mph_next = mph + 1'b1;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.wr     = 1'b1;
          pc_next    = pc + 1'b1;
          state_next = S_FETCH;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      mph       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      mph   <= mph_next;
      if (cmd.publish)    out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // a result beat is never overwritten while it still waits
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("result overwritten while output stalled");

  // an accepted beat starts the program from its first step
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_FETCH && pc == '0))
    else $error("program did not start after accept");

  // divider wait only happens for a divide step
  a_div_op: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (ins.op == OP_DIV))
    else $error("divider wait on a non-divide step");

  // the program counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (pc < PROG_LEN))
    else $error("program counter out of range");

endmodule

@@ rtl/core/env_sensor_compensation.sv @@
// Sequencing: each program step passes through a fetch and an execute state; a 64-bit
//   multiply also steps through the partial-product phases on the shared 32x32 multiplier,
//   and a divide waits in its own state until the 64-step divide is done.
// Flow: one beat at a time; the next input is taken once the sequencer is idle, while
//   the previous result may still wait at the output.
// Reset clears the sequencer, coefficient registers and the fine temperature to 0.
module env_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ensc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ensc_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [ensc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ensc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ensc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ensc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ensc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule
